// ----- design/rhc_pkg.sv -----
// Shared types, widths and constants of the RGB to HSI converter.
package rhc_pkg;

	localparam int COMPONENT_BITS = 6;
	localparam int CORDIC_STEPS   = 40;

	localparam int SUM_W   = COMPONENT_BITS + 2;
	localparam int X0_W    = COMPONENT_BITS + 2;
	localparam int SQ_W    = 2 * COMPONENT_BITS + 42;
	localparam int NSQ     = SQ_W / 2;
	localparam int XW      = COMPONENT_BITS + 25;
	localparam int ZW      = 44;
	localparam int HZ_W    = 43;
	localparam int HN_W    = HZ_W + 14;
	localparam int HUE_QW  = 15;
	localparam int HUE_SH  = 45;
	localparam int HR_W    = 17;
	localparam int HP_W    = HZ_W + HR_W;
	localparam int HE_W    = HN_W + 1;
	localparam int SAT_NW  = SUM_W + 17;
	localparam int SAT_DW  = SUM_W + 1;
	localparam int SAT_QW  = 16;
	localparam int INT_NW  = SUM_W + 14 - COMPONENT_BITS;
	localparam int INT_SH  = 17;
	localparam int INT_RW  = 16;
	localparam int IP_W    = INT_NW + INT_RW;
	localparam int INT_QW  = 14;
	localparam int DIV_LAT = SAT_QW;

	localparam longint unsigned HUE_SCALE = 11520;
	localparam longint unsigned SAT_ONE   = 32768;
	localparam longint unsigned INT_RECIP = ((64'd1 << INT_SH) + 2) / 3;

	typedef struct packed {
		logic [COMPONENT_BITS-1:0] red_code;
		logic [COMPONENT_BITS-1:0] green_code;
		logic [COMPONENT_BITS-1:0] blue_code;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] hue_deg;
		logic               is_grey;
		logic [15:0]        saturation;
		logic [13:0]        intensity;
	} hsi_t;

	function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned rem;
		q   = 0;
		rem = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 1) | ((n >> i) & 64'd1);
			if (rem >= d) begin
				rem = rem - d;
				q   = q | (64'd1 << i);
			end
		end
		return q;
	endfunction

	function automatic longint unsigned atan_inv5_q60();
		longint unsigned p;
		longint unsigned k;
		longint          acc;
		longint          term;
		p   = cdiv(64'd1 << 60, 64'd5);
		k   = 0;
		acc = 0;
		while (p != 0) begin
			term = longint'(cdiv(p, 2 * k + 1));
			acc  = k[0] ? acc - term : acc + term;
			p    = cdiv(p, 64'd25);
			k    = k + 1;
		end
		return longint'(acc);
	endfunction

	function automatic longint unsigned atan_inv239_q60();
		longint unsigned p;
		longint unsigned k;
		longint          acc;
		longint          term;
		p   = cdiv(64'd1 << 60, 64'd239);
		k   = 0;
		acc = 0;
		while (p != 0) begin
			term = longint'(cdiv(p, 2 * k + 1));
			acc  = k[0] ? acc - term : acc + term;
			p    = cdiv(p, 64'd57121);
			k    = k + 1;
		end
		return longint'(acc);
	endfunction

	function automatic longint unsigned atan_pow2_q60(int i);
		longint unsigned p;
		longint unsigned k;
		longint          acc;
		longint          term;
		p   = (i < 60) ? (64'd1 << (60 - i)) : 64'd0;
		k   = 0;
		acc = 0;
		while (p != 0) begin
			term = longint'(cdiv(p, 2 * k + 1));
			acc  = k[0] ? acc - term : acc + term;
			p    = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
			k    = k + 1;
		end
		return longint'(acc);
	endfunction

	function automatic longint q60_to_q40(longint unsigned v);
		return longint'((v + (64'd1 << 19)) >> 20);
	endfunction

	localparam longint unsigned QUARTER60 = 4 * atan_inv5_q60() - atan_inv239_q60();
	localparam longint PI40 = q60_to_q40(4 * QUARTER60);

	localparam longint unsigned HUE_RECIP =
		(HUE_SCALE * (64'd1 << HUE_SH) + longint'(PI40) / 2) / longint'(PI40);

	function automatic longint cordic_ang(int i);
		return (i == 0) ? q60_to_q40(QUARTER60) : q60_to_q40(atan_pow2_q60(i));
	endfunction

	localparam logic signed [15:0] GREY_HUE =
		16'(-((longint'(64'd1 << 40) * longint'(HUE_SCALE) + PI40 / 2) / PI40));

endpackage

// ----- design/rhc_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module rhc_udiv #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 9,
	parameter int QUO_W = 16
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int TW = NUM_W + QUO_W + DEN_W;

	logic [NUM_W-1:0] rem_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int J = QUO_W - 1 - k;
		logic [NUM_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [QUO_W-1:0] quo_i;
		logic [TW-1:0]    dsh;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[k];
			assign den_i = den_s[k];
			assign quo_i = quo_s[k];
		end

		assign dsh = TW'(den_i) << J;
		assign ge  = TW'(rem_i) >= dsh;

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_i - NUM_W'(dsh) : rem_i;
			den_s[k+1] <= den_i;
			quo_s[k+1] <= ge ? (quo_i | (QUO_W'(1) << J)) : quo_i;
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

// ----- design/rgb_to_hsi_converter.sv -----
// Top level of the pipelined RGB to HSI converter.
//
//   port      dir  width         meaning
//   start     in   1             request strobe, taken when busy is low
//   request   in   pixel_t       red, green and blue codes
//   busy      out  1             always low, a request is taken every cycle
//   done      out  1             result strobe, one cycle per request
//   result    out  hsi_t         hue, grey flag, saturation, intensity
//
// A request passes through the square root stages, the CORDIC stages and the saturation
// divider, with registers between them and at the output.
// One request per cycle, results leave in request order.
// Reset clears the valid chain only; payload registers are not reset.
// The receiver cannot stall, so no stage ever holds.
module rgb_to_hsi_converter
	import rhc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  pixel_t request,
	output logic   busy,
	output logic   done,
	output hsi_t   result
);

	localparam int CW       = COMPONENT_BITS;
	localparam int PIPE_LAT = 3 + NSQ + CORDIC_STEPS + DIV_LAT;
	localparam int HUE_LAT  = 4;

	typedef struct packed {
		logic signed [X0_W-1:0] x0;
		logic                   grey;
		logic                   gltb;
		logic [SUM_W-1:0]       sum;
		logic [CW-1:0]          mn;
	} ctx_t;

	typedef struct packed {
		logic grey;
		logic zero;
	} flag_t;

	logic                 accept;
	logic [PIPE_LAT-1:0]  vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	logic [CW-1:0]          r_c, g_c, b_c, d_c, mn_c;
	logic signed [X0_W-1:0] x0_c;
	logic [SQ_W-1:0]        v_c;

	assign r_c  = request.red_code;
	assign g_c  = request.green_code;
	assign b_c  = request.blue_code;
	assign x0_c = (X0_W'(r_c) << 1) - X0_W'(g_c) - X0_W'(b_c);
	assign d_c  = (g_c > b_c) ? g_c - b_c : b_c - g_c;
	assign v_c  = (SQ_W'(d_c) * SQ_W'(d_c) * SQ_W'(3)) << 40;

	always_comb begin
		mn_c = r_c;
		if (g_c < mn_c) begin
			mn_c = g_c;
		end
		if (b_c < mn_c) begin
			mn_c = b_c;
		end
	end

	logic [SQ_W-1:0] sq_v_s   [0:NSQ];
	logic [SQ_W-1:0] sq_res_s [0:NSQ];
	ctx_t            sq_ctx_s [0:NSQ];

	always_ff @(posedge clk) begin
		sq_v_s[0]        <= v_c;
		sq_res_s[0]      <= '0;
		sq_ctx_s[0].x0   <= x0_c;
		sq_ctx_s[0].grey <= (r_c == g_c) && (g_c == b_c);
		sq_ctx_s[0].gltb <= g_c < b_c;
		sq_ctx_s[0].sum  <= SUM_W'(r_c) + SUM_W'(g_c) + SUM_W'(b_c);
		sq_ctx_s[0].mn   <= mn_c;
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] trial;
		logic            ge;

		assign trial = sq_res_s[k] + BIT;
		assign ge    = sq_v_s[k] >= trial;

		always_ff @(posedge clk) begin
			sq_v_s[k+1]   <= ge ? sq_v_s[k] - trial : sq_v_s[k];
			sq_res_s[k+1] <= ge ? (sq_res_s[k] >> 1) + BIT : sq_res_s[k] >> 1;
			sq_ctx_s[k+1] <= sq_ctx_s[k];
		end
	end

	localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI40);
	localparam logic signed [ZW-1:0] HALF_Z = ZW'(PI40 / 2);
	localparam logic signed [HE_W-1:0] PI_E = HE_W'(PI40);

	logic signed [XW-1:0] cx_s   [0:CORDIC_STEPS];
	logic signed [XW-1:0] cy_s   [0:CORDIC_STEPS];
	logic signed [ZW-1:0] cz_s   [0:CORDIC_STEPS];
	ctx_t                 cctx_s [0:CORDIC_STEPS];

	logic signed [XW-1:0] x0e_c, y0_c;

	assign x0e_c = {{(XW - X0_W - 20){sq_ctx_s[NSQ].x0[X0_W-1]}}, sq_ctx_s[NSQ].x0, 20'b0};
	assign y0_c  = XW'(sq_res_s[NSQ]);

	always_ff @(posedge clk) begin
		if (sq_ctx_s[NSQ].x0 < 0) begin
			cx_s[0] <= y0_c;
			cy_s[0] <= -x0e_c;
			cz_s[0] <= HALF_Z;
		end else begin
			cx_s[0] <= x0e_c;
			cy_s[0] <= y0_c;
			cz_s[0] <= '0;
		end
		cctx_s[0] <= sq_ctx_s[NSQ];
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] ANG = ZW'(cordic_ang(i));
		logic signed [XW-1:0] xs, ys;

		assign xs = cx_s[i][XW-1] ? -((-cx_s[i]) >>> i) : (cx_s[i] >>> i);
		assign ys = cy_s[i][XW-1] ? -((-cy_s[i]) >>> i) : (cy_s[i] >>> i);

		always_ff @(posedge clk) begin
			if (cy_s[i][XW-1]) begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - ANG;
			end else if (cy_s[i] != 0) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + ANG;
			end else begin
				cx_s[i+1] <= cx_s[i];
				cy_s[i+1] <= cy_s[i];
				cz_s[i+1] <= cz_s[i];
			end
			cctx_s[i+1] <= cctx_s[i];
		end
	end

	ctx_t                 pctx;
	logic signed [ZW-1:0] zl_c;
	logic [HZ_W-1:0]      zc_c;
	logic [HN_W-1:0]      zn_c;
	logic [SUM_W-1:0]     mn3_c;

	assign pctx = cctx_s[CORDIC_STEPS];

	always_comb begin
		if (cz_s[CORDIC_STEPS] < 0) begin
			zl_c = '0;
		end else if (cz_s[CORDIC_STEPS] > PI_Z) begin
			zl_c = PI_Z;
		end else begin
			zl_c = cz_s[CORDIC_STEPS];
		end
		zc_c = pctx.gltb ? HZ_W'((PI_Z <<< 1) - zl_c) : HZ_W'(zl_c);
	end

	assign zn_c  = HN_W'(zc_c);
	assign mn3_c = (SUM_W'(pctx.mn) << 1) + SUM_W'(pctx.mn);

	logic [HZ_W-1:0]   hue_z_s;
	logic [HN_W-1:0]   hue_num_s;
	logic [SAT_NW-1:0] sat_num_s;
	logic [SAT_DW-1:0] sat_den_s;
	logic [INT_NW-1:0] int_num_s;
	flag_t             flag_s [0:DIV_LAT];

	always_ff @(posedge clk) begin
		hue_z_s        <= zc_c;
		hue_num_s      <= (zn_c << 13) + (zn_c << 11) + (zn_c << 10) + (zn_c << 8)
		                  + HN_W'(HALF_Z);
		sat_num_s      <= (SAT_NW'(pctx.sum - mn3_c) << 16) + SAT_NW'(pctx.sum);
		sat_den_s      <= {pctx.sum, 1'b0};
		int_num_s      <= (INT_NW'(pctx.sum) << (14 - CW)) + INT_NW'(1);
		flag_s[0].grey <= pctx.grey;
		flag_s[0].zero <= pctx.sum == '0;
	end

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_flag
		always_ff @(posedge clk) begin
			flag_s[k+1] <= flag_s[k];
		end
	end

	logic [SAT_QW-1:0] sat_quo;

	rhc_udiv #(.NUM_W(SAT_NW), .DEN_W(SAT_DW), .QUO_W(SAT_QW)) u_sat_div (
		.clk (clk),
		.num (sat_num_s),
		.den (sat_den_s),
		.quo (sat_quo)
	);

	logic [HP_W-1:0]        hue_prod_c, hue_rnd_c;
	logic [HP_W-1:0]        hue_prod_s;
	logic [HN_W-1:0]        hue_n1_s, hue_n2_s;
	logic [HUE_QW-1:0]      hue_est_s, hue_est2_s;
	logic signed [HE_W-1:0] hue_err_s;
	logic [HUE_QW-1:0]      hue_dly_s [HUE_LAT:DIV_LAT];
	logic [IP_W-1:0]        int_prod_c;
	logic [INT_QW-1:0]      int_dly_s [1:DIV_LAT];

	assign hue_prod_c = HP_W'(hue_z_s) * HP_W'(HUE_RECIP);
	assign hue_rnd_c  = hue_prod_s + HP_W'(64'd1 << (HUE_SH - 1));
	assign int_prod_c = IP_W'(int_num_s) * IP_W'(INT_RECIP);

	always_ff @(posedge clk) begin
		hue_prod_s <= hue_prod_c;
		hue_n1_s   <= hue_num_s;
		hue_est_s  <= hue_rnd_c[HUE_SH +: HUE_QW];
		hue_n2_s   <= hue_n1_s;
		hue_err_s  <= HE_W'(hue_n2_s) - HE_W'(hue_est_s) * PI_E;
		hue_est2_s <= hue_est_s;
		if (hue_err_s < 0) begin
			hue_dly_s[HUE_LAT] <= hue_est2_s - HUE_QW'(1);
		end else if (hue_err_s >= PI_E) begin
			hue_dly_s[HUE_LAT] <= hue_est2_s + HUE_QW'(1);
		end else begin
			hue_dly_s[HUE_LAT] <= hue_est2_s;
		end
		int_dly_s[1] <= int_prod_c[INT_SH +: INT_QW];
	end

	for (genvar j = HUE_LAT; j < DIV_LAT; j++) begin : g_hue_dly
		always_ff @(posedge clk) begin
			hue_dly_s[j+1] <= hue_dly_s[j];
		end
	end

	for (genvar j = 1; j < DIV_LAT; j++) begin : g_int_dly
		always_ff @(posedge clk) begin
			int_dly_s[j+1] <= int_dly_s[j];
		end
	end

	hsi_t res_q;
	logic done_q;

	always_ff @(posedge clk) begin
		res_q.hue_deg    <= flag_s[DIV_LAT].grey ? GREY_HUE : 16'(hue_dly_s[DIV_LAT]);
		res_q.is_grey    <= flag_s[DIV_LAT].grey;
		res_q.saturation <= flag_s[DIV_LAT].zero ? 16'(SAT_ONE) : sat_quo;
		res_q.intensity  <= flag_s[DIV_LAT].zero ? '0 : int_dly_s[DIV_LAT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[PIPE_LAT-1];
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(PIPE_LAT + 1) done)
		else $error("request did not produce a result at the pipeline latency");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_grey |-> result.hue_deg == GREY_HUE)
		else $error("grey pixel without the grey hue code");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_grey |-> result.hue_deg >= 0 && result.hue_deg <= 16'sd23040)
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.saturation <= 16'(SAT_ONE))
		else $error("saturation above one");

endmodule
